FILE: src/jssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jssc_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int STACK_SLOTS = MAX_DEPTH + 1;
    localparam int LEVEL_W     = $clog2(STACK_SLOTS + 1);
    localparam int SLOT_W      = $clog2(STACK_SLOTS);
    localparam int FIFO_DEPTH  = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic       accepted;
        logic [4:0] error_code;
    } out_word_t;

    // error codes
    localparam logic [4:0] E_NONE    = 5'd0;
    localparam logic [4:0] E_END     = 5'd1;
    localparam logic [4:0] E_DEPTH   = 5'd2;
    localparam logic [4:0] E_LIT     = 5'd3;
    localparam logic [4:0] E_KEY     = 5'd4;
    localparam logic [4:0] E_COLON   = 5'd5;
    localparam logic [4:0] E_OBJSEP  = 5'd6;
    localparam logic [4:0] E_ARRSEP  = 5'd7;
    localparam logic [4:0] E_NUM     = 5'd8;
    localparam logic [4:0] E_FRAC    = 5'd9;
    localparam logic [4:0] E_EXP     = 5'd10;
    localparam logic [4:0] E_UNTERM  = 5'd11;
    localparam logic [4:0] E_CTRL    = 5'd12;
    localparam logic [4:0] E_ESC     = 5'd13;
    localparam logic [4:0] E_HEX     = 5'd14;
    localparam logic [4:0] E_LHIGH   = 5'd15;
    localparam logic [4:0] E_BADLOW  = 5'd16;
    localparam logic [4:0] E_LLOW    = 5'd17;
    localparam logic [4:0] E_UTF8    = 5'd18;

    typedef enum logic [4:0] {
        M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_AFTER,
        M_LIT_T, M_LIT_F, M_LIT_N,
        M_N_SIGN, M_N_ZERO, M_N_INT, M_N_DOT, M_N_FRAC, M_N_E, M_N_ESIGN, M_N_EXP,
        M_STR, M_ESC, M_UHEX, M_UHEX_BAD, M_HIGH, M_HIGH_BS, M_LHEX, M_LHEX_BAD
    } mode_t;

    // byte classes produced by the front end
    typedef struct packed {
        logic       ws;
        logic       digit;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       ctrl;
        logic       esc_simple;
    } byte_class_t;

    typedef struct packed {
        in_word_t    word;
        byte_class_t cls;
    } cls_word_t;

    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            2'd0: case (idx)
                3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
            endcase
            2'd1: case (idx)
                3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
                default: c = 8'h00;
            endcase
            2'd2: case (idx)
                3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] w);
        return (w == 2'd1) ? 3'd5 : 3'd4;
    endfunction

endpackage
`default_nettype wire

FILE: src/jssc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte classifier feeding a small word queue
module jssc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire jssc_pkg::in_word_t  in_word,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output jssc_pkg::cls_word_t      q_word,
    output logic                     q_valid,
    input  wire logic                q_stall
);
    jssc_pkg::cls_word_t mem_reg [jssc_pkg::FIFO_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;
    jssc_pkg::byte_class_t cls;
    logic [7:0] b;

    // classification
    always_comb
    begin
        b = in_word.data_byte;
        cls.ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
        cls.digit = (b >= "0") && (b <= "9");
        cls.ctrl = (b < 8'h20);
        cls.esc_simple = (b == "\"") || (b == "\\") || (b == "/") || (b == "b") ||
                         (b == "f") || (b == "n") || (b == "r") || (b == "t");
        cls.hex_ok = 1'b1;
        cls.hex_val = 4'd0;
        if (cls.digit)
            cls.hex_val = b[3:0];
        else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
            cls.hex_val = b[3:0] + 4'd9;
        else
            cls.hex_ok = 1'b0;
    end

    assign in_stall = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign push     = in_valid && !in_stall;
    assign pop      = q_valid && !q_stall;
    assign q_word   = mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{word: in_word, cls: cls};
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("bad queue count");
`endif
endmodule
`default_nettype wire

FILE: src/jssc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Grammar state machine with result register
module jssc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire jssc_pkg::cls_word_t q_word,
    input  wire logic                q_valid,
    output logic                     q_stall,
    output jssc_pkg::out_word_t      out_word,
    output logic                     out_valid,
    input  wire logic                out_stall
);
    localparam logic [jssc_pkg::LEVEL_W-1:0] MAXD = jssc_pkg::LEVEL_W'(jssc_pkg::MAX_DEPTH);
    localparam logic [jssc_pkg::LEVEL_W-1:0] SLOTS =
        jssc_pkg::LEVEL_W'(jssc_pkg::STACK_SLOTS);

    logic [jssc_pkg::STACK_SLOTS-1:0] stack_reg;
    jssc_pkg::mode_t                mode_reg, mode_next;
    logic [jssc_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [2:0]                     lit_reg, lit_next;
    logic [15:0]                    hex_reg, hex_next;
    logic [2:0]                     hcnt_reg, hcnt_next;
    logic [2:0]                     u8_reg, u8_next;
    logic [4:0]                     err_reg, err_next;
    logic                           u8bad_reg, u8bad_next;
    logic                           key_reg, key_next;
    logic                           push_en;
    logic                           pop_en;
    logic                           push_obj;
    jssc_pkg::out_word_t            res_reg;
    logic                           res_valid_reg;

    logic        take;
    logic [7:0]  b;
    jssc_pkg::byte_class_t c;
    logic        top_obj;
    logic [4:0]  raise;
    logic [4:0]  endc;
    logic [4:0]  fin_err;

    assign b = q_word.word.data_byte;
    assign c = q_word.cls;
    // only a final byte has to wait for a held verdict
    assign q_stall = res_valid_reg && out_stall && q_word.word.final_byte;
    assign take = q_valid && !q_stall;
    assign out_word = res_reg;
    assign out_valid = res_valid_reg;

    assign top_obj = (level_reg != '0) && (level_reg <= SLOTS) && stack_reg[0];

    // per-byte grammar step
    always_comb
    begin
        logic [15:0] hacc;
        logic        hbad;
        logic [7:0]  lo, hi;
        logic [2:0]  nx;
        logic [1:0]  w;
        mode_next  = mode_reg;
        level_next = level_reg;
        lit_next   = lit_reg;
        hex_next   = hex_reg;
        hcnt_next  = hcnt_reg;
        u8_next    = u8_reg;
        u8bad_next = u8bad_reg;
        key_next   = key_reg;
        push_en    = 1'b0;
        pop_en     = 1'b0;
        push_obj   = 1'b0;
        raise      = jssc_pkg::E_NONE;
        hacc = '0; hbad = 1'b0; lo = 8'h80; hi = 8'hBF; nx = '0;
        w = 2'(mode_reg - jssc_pkg::M_LIT_T);
        case (mode_reg)
            jssc_pkg::M_VALUE, jssc_pkg::M_ARR_FIRST:
            begin
                if (c.ws)
                begin
                end
                else if (mode_reg == jssc_pkg::M_ARR_FIRST && b == "]")
                begin
                    if (level_reg != '0)
                    begin
                        level_next = level_reg - 1'b1;
                        pop_en = 1'b1;
                    end
                    mode_next = jssc_pkg::M_AFTER;
                end
                else if (level_reg > MAXD)
                    raise = jssc_pkg::E_DEPTH;
                else if (b == "{" || b == "[")
                begin
                    push_obj = (b == "{");
                    if (level_reg < SLOTS)
                    begin
                        push_en = 1'b1;
                        level_next = level_reg + 1'b1;
                    end
                    mode_next = push_obj ? jssc_pkg::M_OBJ_FIRST : jssc_pkg::M_ARR_FIRST;
                end
                else if (b == "\"")
                begin
                    key_next = 1'b0; u8bad_next = 1'b0; u8_next = '0;
                    mode_next = jssc_pkg::M_STR;
                end
                else if (b == "t")
                begin
                    mode_next = jssc_pkg::M_LIT_T; lit_next = 3'd1;
                end
                else if (b == "f")
                begin
                    mode_next = jssc_pkg::M_LIT_F; lit_next = 3'd1;
                end
                else if (b == "n")
                begin
                    mode_next = jssc_pkg::M_LIT_N; lit_next = 3'd1;
                end
                else if (b == "-") mode_next = jssc_pkg::M_N_SIGN;
                else if (b == "0") mode_next = jssc_pkg::M_N_ZERO;
                else if (c.digit)  mode_next = jssc_pkg::M_N_INT;
                else raise = jssc_pkg::E_NUM;
            end
            jssc_pkg::M_OBJ_FIRST, jssc_pkg::M_OBJ_KEY:
            begin
                if (c.ws)
                begin
                end
                else if (mode_reg == jssc_pkg::M_OBJ_FIRST && b == "}")
                begin
                    if (level_reg != '0)
                    begin
                        level_next = level_reg - 1'b1;
                        pop_en = 1'b1;
                    end
                    mode_next = jssc_pkg::M_AFTER;
                end
                else if (b == "\"")
                begin
                    key_next = 1'b1; u8bad_next = 1'b0; u8_next = '0;
                    mode_next = jssc_pkg::M_STR;
                end
                else raise = jssc_pkg::E_KEY;
            end
            jssc_pkg::M_COLON:
            begin
                if (!c.ws)
                begin
                    if (b == ":") mode_next = jssc_pkg::M_VALUE;
                    else raise = jssc_pkg::E_COLON;
                end
            end
            jssc_pkg::M_LIT_T, jssc_pkg::M_LIT_F, jssc_pkg::M_LIT_N:
            begin
                if (lit_reg < jssc_pkg::lit_len(w) && b == jssc_pkg::lit_char(w, lit_reg))
                begin
                    lit_next = lit_reg + 3'd1;
                    if (lit_next == jssc_pkg::lit_len(w))
                    begin
                        lit_next = '0;
                        mode_next = jssc_pkg::M_AFTER;
                    end
                end
                else raise = jssc_pkg::E_LIT;
            end
            jssc_pkg::M_N_SIGN:
            begin
                if (b == "0") mode_next = jssc_pkg::M_N_ZERO;
                else if (c.digit) mode_next = jssc_pkg::M_N_INT;
                else raise = jssc_pkg::E_NUM;
            end
            jssc_pkg::M_N_DOT:
            begin
                if (c.digit) mode_next = jssc_pkg::M_N_FRAC;
                else raise = jssc_pkg::E_FRAC;
            end
            jssc_pkg::M_N_E, jssc_pkg::M_N_ESIGN:
            begin
                if (c.digit) mode_next = jssc_pkg::M_N_EXP;
                else if (mode_reg == jssc_pkg::M_N_E && (b == "+" || b == "-"))
                    mode_next = jssc_pkg::M_N_ESIGN;
                else raise = jssc_pkg::E_EXP;
            end
            jssc_pkg::M_AFTER, jssc_pkg::M_N_ZERO, jssc_pkg::M_N_INT,
            jssc_pkg::M_N_FRAC, jssc_pkg::M_N_EXP:
            begin
                if (c.digit && (mode_reg == jssc_pkg::M_N_INT ||
                    mode_reg == jssc_pkg::M_N_FRAC || mode_reg == jssc_pkg::M_N_EXP))
                begin
                end
                else if (b == "." && (mode_reg == jssc_pkg::M_N_ZERO ||
                         mode_reg == jssc_pkg::M_N_INT))
                    mode_next = jssc_pkg::M_N_DOT;
                else if ((b == "e" || b == "E") && mode_reg != jssc_pkg::M_AFTER &&
                         mode_reg != jssc_pkg::M_N_EXP)
                    mode_next = jssc_pkg::M_N_E;
                else
                begin
                    // after-value handling
                    mode_next = jssc_pkg::M_AFTER;
                    if (c.ws)
                    begin
                    end
                    else if (level_reg == '0) raise = jssc_pkg::E_UTF8;
                    else if (top_obj)
                    begin
                        if (b == ",") mode_next = jssc_pkg::M_OBJ_KEY;
                        else if (b == "}")
                        begin
                            level_next = level_reg - 1'b1;
                            pop_en = 1'b1;
                        end
                        else raise = jssc_pkg::E_OBJSEP;
                    end
                    else
                    begin
                        if (b == ",") mode_next = jssc_pkg::M_VALUE;
                        else if (b == "]")
                        begin
                            level_next = level_reg - 1'b1;
                            pop_en = 1'b1;
                        end
                        else raise = jssc_pkg::E_ARRSEP;
                    end
                end
            end
            jssc_pkg::M_STR:
            begin
                if (b == "\"")
                begin
                    if (u8bad_reg || u8_reg != '0) raise = jssc_pkg::E_UTF8;
                    else mode_next = key_reg ? jssc_pkg::M_COLON : jssc_pkg::M_AFTER;
                end
                else if (c.ctrl) raise = jssc_pkg::E_CTRL;
                else if (b == "\\")
                begin
                    if (u8_reg != '0)
                    begin
                        u8bad_next = 1'b1; u8_next = '0;
                    end
                    mode_next = jssc_pkg::M_ESC;
                end
                else if (!u8bad_reg)
                begin
                    if (u8_reg == '0)
                    begin
                        if (b < 8'h80) u8_next = '0;
                        else if (b >= 8'hC2 && b <= 8'hDF) u8_next = 3'd1;
                        else if (b == 8'hE0) u8_next = 3'd4;
                        else if (b == 8'hED) u8_next = 3'd5;
                        else if (b >= 8'hE1 && b <= 8'hEF) u8_next = 3'd2;
                        else if (b == 8'hF0) u8_next = 3'd6;
                        else if (b >= 8'hF1 && b <= 8'hF3) u8_next = 3'd3;
                        else if (b == 8'hF4) u8_next = 3'd7;
                        else u8bad_next = 1'b1;
                    end
                    else
                    begin
                        nx = u8_reg - 3'd1;
                        case (u8_reg)
                            3'd4:
                            begin
                                lo = 8'hA0; nx = 3'd1;
                            end
                            3'd5:
                            begin
                                hi = 8'h9F; nx = 3'd1;
                            end
                            3'd6:
                            begin
                                lo = 8'h90; nx = 3'd2;
                            end
                            3'd7:
                            begin
                                hi = 8'h8F; nx = 3'd2;
                            end
                            default: ;
                        endcase
                        if (b < lo || b > hi)
                        begin
                            u8bad_next = 1'b1; u8_next = '0;
                        end
                        else u8_next = nx;
                    end
                end
            end
            jssc_pkg::M_ESC:
            begin
                if (c.esc_simple) mode_next = jssc_pkg::M_STR;
                else if (b == "u")
                begin
                    hex_next = '0; hcnt_next = '0; mode_next = jssc_pkg::M_UHEX;
                end
                else raise = jssc_pkg::E_ESC;
            end
            jssc_pkg::M_UHEX, jssc_pkg::M_UHEX_BAD, jssc_pkg::M_LHEX, jssc_pkg::M_LHEX_BAD:
            begin
                hbad = (mode_reg == jssc_pkg::M_UHEX_BAD) ||
                       (mode_reg == jssc_pkg::M_LHEX_BAD) || !c.hex_ok;
                hacc = c.hex_ok ? {hex_reg[11:0], c.hex_val} : hex_reg;
                hex_next = hacc;
                hcnt_next = hcnt_reg + 3'd1;
                if (hbad)
                    mode_next = (mode_reg == jssc_pkg::M_LHEX ||
                                 mode_reg == jssc_pkg::M_LHEX_BAD) ?
                                jssc_pkg::M_LHEX_BAD : jssc_pkg::M_UHEX_BAD;
                if (hcnt_next >= 3'd4)
                begin
                    if (hbad) raise = jssc_pkg::E_HEX;
                    else if (mode_reg == jssc_pkg::M_LHEX)
                    begin
                        if (hacc >= 16'hDC00 && hacc <= 16'hDFFF) mode_next = jssc_pkg::M_STR;
                        else raise = jssc_pkg::E_BADLOW;
                    end
                    else if (hacc >= 16'hD800 && hacc <= 16'hDBFF)
                        mode_next = jssc_pkg::M_HIGH;
                    else if (hacc >= 16'hDC00 && hacc <= 16'hDFFF)
                        raise = jssc_pkg::E_LLOW;
                    else mode_next = jssc_pkg::M_STR;
                end
            end
            jssc_pkg::M_HIGH:
            begin
                if (b == "\\") mode_next = jssc_pkg::M_HIGH_BS;
                else raise = jssc_pkg::E_LHIGH;
            end
            jssc_pkg::M_HIGH_BS:
            begin
                if (b == "u")
                begin
                    hex_next = '0; hcnt_next = '0; mode_next = jssc_pkg::M_LHEX;
                end
                else raise = jssc_pkg::E_LHIGH;
            end
            default: raise = jssc_pkg::E_END;
        endcase
        err_next = raise;
    end

    // end-of-document code from the state after this byte
    always_comb
    begin
        logic lobj;
        lobj = (level_next != '0) &&
               (push_en ? push_obj : (pop_en ? stack_reg[1] : stack_reg[0]));
        case (mode_next)
            jssc_pkg::M_VALUE, jssc_pkg::M_ARR_FIRST:
                endc = (level_next > MAXD) ? jssc_pkg::E_DEPTH : jssc_pkg::E_END;
            jssc_pkg::M_OBJ_FIRST, jssc_pkg::M_OBJ_KEY: endc = jssc_pkg::E_KEY;
            jssc_pkg::M_COLON: endc = jssc_pkg::E_COLON;
            jssc_pkg::M_AFTER, jssc_pkg::M_N_ZERO, jssc_pkg::M_N_INT,
            jssc_pkg::M_N_FRAC, jssc_pkg::M_N_EXP:
                endc = (level_next == '0) ? jssc_pkg::E_NONE :
                       (lobj ? jssc_pkg::E_OBJSEP : jssc_pkg::E_ARRSEP);
            jssc_pkg::M_LIT_T, jssc_pkg::M_LIT_F, jssc_pkg::M_LIT_N: endc = jssc_pkg::E_LIT;
            jssc_pkg::M_N_SIGN: endc = jssc_pkg::E_NUM;
            jssc_pkg::M_N_DOT: endc = jssc_pkg::E_FRAC;
            jssc_pkg::M_N_E, jssc_pkg::M_N_ESIGN: endc = jssc_pkg::E_EXP;
            jssc_pkg::M_HIGH, jssc_pkg::M_HIGH_BS: endc = jssc_pkg::E_LHIGH;
            jssc_pkg::M_STR, jssc_pkg::M_ESC, jssc_pkg::M_UHEX, jssc_pkg::M_UHEX_BAD,
            jssc_pkg::M_LHEX, jssc_pkg::M_LHEX_BAD: endc = jssc_pkg::E_UNTERM;
            default: endc = jssc_pkg::E_END;
        endcase
        if (err_reg != jssc_pkg::E_NONE) fin_err = err_reg;
        else if (err_next != jssc_pkg::E_NONE) fin_err = err_next;
        else fin_err = endc;
    end

    // container stack: shift register, innermost container in bit 0
    always_ff @(posedge clk)
    begin
        if (take && err_reg == jssc_pkg::E_NONE)
        begin
            if (push_en)
                stack_reg <= {stack_reg[jssc_pkg::STACK_SLOTS-2:0], push_obj};
            else if (pop_en)
                stack_reg <= {1'b0, stack_reg[jssc_pkg::STACK_SLOTS-1:1]};
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && q_word.word.final_byte)
            res_reg <= '{accepted: (fin_err == jssc_pkg::E_NONE), error_code: fin_err};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jssc_pkg::M_VALUE;
            level_reg <= '0; lit_reg <= '0; hex_reg <= '0; hcnt_reg <= '0;
            u8_reg <= '0; err_reg <= '0; u8bad_reg <= 1'b0; key_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !out_stall) res_valid_reg <= 1'b0;
            if (take)
            begin
                if (q_word.word.final_byte)
                begin
                    res_valid_reg <= 1'b1;
                    mode_reg <= jssc_pkg::M_VALUE;
                    level_reg <= '0; lit_reg <= '0; hex_reg <= '0; hcnt_reg <= '0;
                    u8_reg <= '0; err_reg <= '0; u8bad_reg <= 1'b0; key_reg <= 1'b0;
                end
                else if (err_reg == jssc_pkg::E_NONE)
                begin
                    mode_reg <= mode_next; level_reg <= level_next; lit_reg <= lit_next;
                    hex_reg <= hex_next; hcnt_reg <= hcnt_next; u8_reg <= u8_next;
                    err_reg <= err_next; u8bad_reg <= u8bad_next; key_reg <= key_next;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= SLOTS) else $error("nesting level out of range");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != 5'd0 && !(take && q_word.word.final_byte)) |=> $stable(err_reg))
        else $error("error not sticky");
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.accepted == (out_word.error_code == 5'd0)))
        else $error("verdict mismatch");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

FILE: src/json_strict_syntax_checker.sv
// The final byte passes through the two-word queue to the state machine, which writes the
// verdict into a result register that drives out_word and out_valid.
// Throughput: one byte per cycle sustained; a held verdict stalls only the next final byte.
// A two-word queue parts the byte classifier from the state machine.
// Reset (rst_n low, asynchronous) returns to expect-value at top level with no error.
`timescale 1ns / 1ps
`default_nettype none
module json_strict_syntax_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire jssc_pkg::in_word_t  in_word,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output jssc_pkg::out_word_t      out_word,
    output logic                     out_valid,
    input  wire logic                out_stall
);
    jssc_pkg::cls_word_t q_word;
    logic q_valid, q_stall;

    jssc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .q_word(q_word), .q_valid(q_valid), .q_stall(q_stall)
    );

    jssc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_word(q_word), .q_valid(q_valid), .q_stall(q_stall),
        .out_word(out_word), .out_valid(out_valid), .out_stall(out_stall)
    );
endmodule
`default_nettype wire

FILE: tb/json_verdict_checker.sv
`timescale 1ns / 1ps
module json_verdict_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  jssc_pkg::in_word_t  in_word,
    input  logic                in_valid,
    input  logic                in_stall,
    input  jssc_pkg::out_word_t out_word,
    input  logic                out_valid,
    input  logic                out_stall,
    output int                  fail_count,
    output int                  verdicts_seen,
    output int                  pending_verdicts
);
    // grammar state of the predictor
    jssc_pkg::mode_t     mode;
    logic                kind_stack [jssc_pkg::STACK_SLOTS];
    int unsigned         level;
    int unsigned         lit_pos;
    logic [15:0]         hex_acc;
    int unsigned         hex_n;
    int unsigned         utf_due;
    logic [4:0]          err;
    logic                utf_bad;
    logic                in_key;

    jssc_pkg::out_word_t verdict_q [$];

    function automatic logic ws(input logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    function automatic logic dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int hexv(input logic [7:0] b);
        if (dig(b)) return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] lit_at(input int w, input int i);
        string s;
        s = (w == 0) ? "true" : (w == 1) ? "false" : "null";
        return (i < s.len()) ? s[i] : 8'h00;
    endfunction

    task automatic flag(input logic [4:0] c);
        if (err == jssc_pkg::E_NONE) err = c;
    endtask

    task automatic clear_state();
        mode = jssc_pkg::M_VALUE; level = 0; lit_pos = 0; hex_acc = '0; hex_n = 0;
        utf_due = 0; err = jssc_pkg::E_NONE; utf_bad = 1'b0; in_key = 1'b0;
        foreach (kind_stack[i]) kind_stack[i] = 1'b0;
    endtask

    function automatic logic top_obj();
        if (level == 0 || level > jssc_pkg::STACK_SLOTS) return 1'b0;
        return kind_stack[level-1];
    endfunction

    task automatic open_container(input logic obj);
        if (level < jssc_pkg::STACK_SLOTS)
        begin
            kind_stack[level] = obj;
            level++;
        end
        mode = obj ? jssc_pkg::M_OBJ_FIRST : jssc_pkg::M_ARR_FIRST;
    endtask

    task automatic close_container();
        if (level > 0) level--;
        mode = jssc_pkg::M_AFTER;
    endtask

    task automatic open_str(input logic key);
        in_key = key; utf_bad = 1'b0; utf_due = 0; mode = jssc_pkg::M_STR;
    endtask

    task automatic value_start(input logic [7:0] b);
        if (level > jssc_pkg::MAX_DEPTH)
        begin
            flag(jssc_pkg::E_DEPTH);
            return;
        end
        if (b == "{") open_container(1'b1);
        else if (b == "[") open_container(1'b0);
        else if (b == "\"") open_str(1'b0);
        else if (b == "t")
        begin
            mode = jssc_pkg::M_LIT_T; lit_pos = 1;
        end
        else if (b == "f")
        begin
            mode = jssc_pkg::M_LIT_F; lit_pos = 1;
        end
        else if (b == "n")
        begin
            mode = jssc_pkg::M_LIT_N; lit_pos = 1;
        end
        else if (b == "-") mode = jssc_pkg::M_N_SIGN;
        else if (b == "0") mode = jssc_pkg::M_N_ZERO;
        else if (dig(b)) mode = jssc_pkg::M_N_INT;
        else flag(jssc_pkg::E_NUM);
    endtask

    task automatic value_end(input logic [7:0] b);
        mode = jssc_pkg::M_AFTER;
        if (ws(b)) return;
        if (level == 0)
        begin
            flag(jssc_pkg::E_UTF8);
            return;
        end
        if (top_obj())
        begin
            if (b == ",") mode = jssc_pkg::M_OBJ_KEY;
            else if (b == "}") close_container();
            else flag(jssc_pkg::E_OBJSEP);
        end
        else
        begin
            if (b == ",") mode = jssc_pkg::M_VALUE;
            else if (b == "]") close_container();
            else flag(jssc_pkg::E_ARRSEP);
        end
    endtask

    // raw UTF-8 tracker: 4..7 are the restricted second bytes after E0/ED/F0/F4
    task automatic utf_track(input logic [7:0] b);
        int lo, hi, nxt;
        if (utf_bad) return;
        if (utf_due == 0)
        begin
            if (b < 8'h80) return;
            if (b >= 8'hC2 && b <= 8'hDF) utf_due = 1;
            else if (b == 8'hE0) utf_due = 4;
            else if (b == 8'hED) utf_due = 5;
            else if (b >= 8'hE1 && b <= 8'hEF) utf_due = 2;
            else if (b == 8'hF0) utf_due = 6;
            else if (b >= 8'hF1 && b <= 8'hF3) utf_due = 3;
            else if (b == 8'hF4) utf_due = 7;
            else utf_bad = 1'b1;
            return;
        end
        lo = 'h80; hi = 'hBF; nxt = utf_due - 1;
        case (utf_due)
            4:
            begin
                lo = 'hA0; nxt = 1;
            end
            5:
            begin
                hi = 'h9F; nxt = 1;
            end
            6:
            begin
                lo = 'h90; nxt = 2;
            end
            7:
            begin
                hi = 'h8F; nxt = 2;
            end
            default: ;
        endcase
        if (b < lo || b > hi)
        begin
            utf_bad = 1'b1; utf_due = 0;
        end
        else utf_due = nxt;
    endtask

    task automatic hex_nibble(input logic [7:0] b, input logic low);
        int d;
        logic bad;
        d = hexv(b);
        bad = (mode == jssc_pkg::M_UHEX_BAD || mode == jssc_pkg::M_LHEX_BAD);
        if (d < 0) bad = 1'b1;
        else hex_acc = {hex_acc[11:0], 4'(d)};
        hex_n++;
        if (bad) mode = low ? jssc_pkg::M_LHEX_BAD : jssc_pkg::M_UHEX_BAD;
        if (hex_n < 4) return;
        if (bad)
        begin
            flag(jssc_pkg::E_HEX);
            return;
        end
        if (low)
        begin
            if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) mode = jssc_pkg::M_STR;
            else flag(jssc_pkg::E_BADLOW);
        end
        else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) mode = jssc_pkg::M_HIGH;
        else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) flag(jssc_pkg::E_LLOW);
        else mode = jssc_pkg::M_STR;
    endtask

    task automatic hex_start(input logic low);
        hex_acc = '0; hex_n = 0; mode = low ? jssc_pkg::M_LHEX : jssc_pkg::M_UHEX;
    endtask

    task automatic grammar_step(input logic [7:0] b);
        jssc_pkg::mode_t m;
        int w;
        m = mode;
        case (m)
            jssc_pkg::M_VALUE: if (!ws(b)) value_start(b);
            jssc_pkg::M_ARR_FIRST:
                if (!ws(b))
                begin
                    if (b == "]") close_container();
                    else value_start(b);
                end
            jssc_pkg::M_OBJ_FIRST, jssc_pkg::M_OBJ_KEY:
                if (!ws(b))
                begin
                    if (m == jssc_pkg::M_OBJ_FIRST && b == "}") close_container();
                    else if (b == "\"") open_str(1'b1);
                    else flag(jssc_pkg::E_KEY);
                end
            jssc_pkg::M_COLON:
                if (!ws(b))
                begin
                    if (b == ":") mode = jssc_pkg::M_VALUE;
                    else flag(jssc_pkg::E_COLON);
                end
            jssc_pkg::M_AFTER: value_end(b);
            jssc_pkg::M_LIT_T, jssc_pkg::M_LIT_F, jssc_pkg::M_LIT_N:
            begin
                w = int'(m) - int'(jssc_pkg::M_LIT_T);
                if (lit_pos < ((w == 1) ? 5 : 4) && b == lit_at(w, lit_pos))
                begin
                    lit_pos++;
                    if (lit_pos == ((w == 1) ? 5 : 4))
                    begin
                        lit_pos = 0; mode = jssc_pkg::M_AFTER;
                    end
                end
                else flag(jssc_pkg::E_LIT);
            end
            jssc_pkg::M_N_SIGN:
                if (b == "0") mode = jssc_pkg::M_N_ZERO;
                else if (dig(b)) mode = jssc_pkg::M_N_INT;
                else flag(jssc_pkg::E_NUM);
            jssc_pkg::M_N_ZERO, jssc_pkg::M_N_INT, jssc_pkg::M_N_FRAC:
                if (!(dig(b) && m != jssc_pkg::M_N_ZERO))
                begin
                    if (b == "." && m != jssc_pkg::M_N_FRAC) mode = jssc_pkg::M_N_DOT;
                    else if (b == "e" || b == "E") mode = jssc_pkg::M_N_E;
                    else value_end(b);
                end
            jssc_pkg::M_N_DOT:
                if (dig(b)) mode = jssc_pkg::M_N_FRAC;
                else flag(jssc_pkg::E_FRAC);
            jssc_pkg::M_N_E, jssc_pkg::M_N_ESIGN:
                if (dig(b)) mode = jssc_pkg::M_N_EXP;
                else if (m == jssc_pkg::M_N_E && (b == "+" || b == "-"))
                    mode = jssc_pkg::M_N_ESIGN;
                else flag(jssc_pkg::E_EXP);
            jssc_pkg::M_N_EXP: if (!dig(b)) value_end(b);
            jssc_pkg::M_STR:
                if (b == "\"")
                begin
                    if (utf_bad || utf_due != 0) flag(jssc_pkg::E_UTF8);
                    else mode = in_key ? jssc_pkg::M_COLON : jssc_pkg::M_AFTER;
                end
                else if (b < 8'h20) flag(jssc_pkg::E_CTRL);
                else if (b == "\\")
                begin
                    // an escape cutting a raw multi-byte sequence spoils the string
                    if (utf_due != 0)
                    begin
                        utf_bad = 1'b1; utf_due = 0;
                    end
                    mode = jssc_pkg::M_ESC;
                end
                else utf_track(b);
            jssc_pkg::M_ESC:
                if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                    b == "n" || b == "r" || b == "t") mode = jssc_pkg::M_STR;
                else if (b == "u") hex_start(1'b0);
                else flag(jssc_pkg::E_ESC);
            jssc_pkg::M_UHEX, jssc_pkg::M_UHEX_BAD: hex_nibble(b, 1'b0);
            jssc_pkg::M_LHEX, jssc_pkg::M_LHEX_BAD: hex_nibble(b, 1'b1);
            jssc_pkg::M_HIGH:
                if (b == "\\") mode = jssc_pkg::M_HIGH_BS;
                else flag(jssc_pkg::E_LHIGH);
            jssc_pkg::M_HIGH_BS:
                if (b == "u") hex_start(1'b1);
                else flag(jssc_pkg::E_LHIGH);
            default: flag(jssc_pkg::E_END);
        endcase
    endtask

    function automatic logic [4:0] end_of_doc_code();
        case (mode)
            jssc_pkg::M_VALUE, jssc_pkg::M_ARR_FIRST:
                return (level > jssc_pkg::MAX_DEPTH) ? jssc_pkg::E_DEPTH : jssc_pkg::E_END;
            jssc_pkg::M_OBJ_FIRST, jssc_pkg::M_OBJ_KEY: return jssc_pkg::E_KEY;
            jssc_pkg::M_COLON: return jssc_pkg::E_COLON;
            jssc_pkg::M_AFTER, jssc_pkg::M_N_ZERO, jssc_pkg::M_N_INT,
            jssc_pkg::M_N_FRAC, jssc_pkg::M_N_EXP:
            begin
                if (level == 0) return jssc_pkg::E_NONE;
                return top_obj() ? jssc_pkg::E_OBJSEP : jssc_pkg::E_ARRSEP;
            end
            jssc_pkg::M_LIT_T, jssc_pkg::M_LIT_F, jssc_pkg::M_LIT_N: return jssc_pkg::E_LIT;
            jssc_pkg::M_N_SIGN: return jssc_pkg::E_NUM;
            jssc_pkg::M_N_DOT: return jssc_pkg::E_FRAC;
            jssc_pkg::M_N_E, jssc_pkg::M_N_ESIGN: return jssc_pkg::E_EXP;
            jssc_pkg::M_HIGH, jssc_pkg::M_HIGH_BS: return jssc_pkg::E_LHIGH;
            default: return jssc_pkg::E_UNTERM;
        endcase
    endfunction

    task automatic report(input string what, input jssc_pkg::out_word_t got);
        $display("[%0t] mismatch: %s (got accepted=%0b code=%0d)", $realtime, what,
                 got.accepted, got.error_code);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        verdicts_seen = 0;
        pending_verdicts = 0;
        clear_state();
    end

    // watch both channels on every edge
    always @(posedge clk)
    begin
        jssc_pkg::out_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (err == jssc_pkg::E_NONE) grammar_step(in_word.data_byte);
                if (in_word.final_byte)
                begin
                    if (err == jssc_pkg::E_NONE) err = end_of_doc_code();
                    want.accepted = (err == jssc_pkg::E_NONE);
                    want.error_code = err;
                    verdict_q = {verdict_q, want};
                    clear_state();
                end
            end
            if (out_valid && !out_stall)
            begin
                verdicts_seen++;
                if (verdict_q.size() == 0) report("verdict with none due", out_word);
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_word.accepted !== want.accepted)
                        report($sformatf("accepted, want %0b", want.accepted), out_word);
                    if (out_word.error_code !== want.error_code)
                        report($sformatf("error_code, want %0d", want.error_code), out_word);
                end
            end
            pending_verdicts = verdict_q.size();
        end
    end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    jssc_pkg::in_word_t  in_word;
    logic                in_valid;
    logic                in_stall;
    jssc_pkg::out_word_t out_word;
    logic                out_valid;
    logic                out_stall;
    int                  fail_count;
    int                  verdicts_seen;
    int                  pending_verdicts;
    int                  cycle_count;
    int                  bytes_sent;
    int                  docs_sent;
    logic                calm;
    byte                 doc [$];

    json_strict_syntax_checker i_dut (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .out_word(out_word), .out_valid(out_valid),
        .out_stall(out_stall)
    );

    json_verdict_checker i_checker (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .out_word(out_word), .out_valid(out_valid),
        .out_stall(out_stall), .fail_count(fail_count), .verdicts_seen(verdicts_seen),
        .pending_verdicts(pending_verdicts)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL json_strict_syntax_checker");
                $finish;
            end
        end
    end

    // receiver stalls in short bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // push one word, optionally after a short gap
    task automatic send_word(input byte b, input logic fin);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_word.data_byte <= b;
        in_word.final_byte <= fin;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_doc(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
        docs_sent++;
    endtask

    task automatic send_queue();
        foreach (doc[i]) send_word(doc[i], i == doc.size() - 1);
        docs_sent++;
        doc.delete();
    endtask

    task automatic put_byte(input byte v);
        doc = {doc, v};
    endtask

    task automatic add(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // random well-formed value, depth-limited
    task automatic gen_value(input int d);
        int  k;
        int  j;
        byte ch;
        k = $urandom_range(0, (d > 3) ? 3 : 6);
        case (k)
            0:
            begin
                j = $urandom_range(0, 2);
                if (j == 0) add("true");
                else if (j == 1) add("false");
                else add("null");
            end
            1:
            begin
                if ($urandom_range(0, 1)) add("-");
                if ($urandom_range(0, 3) == 0) add("0");
                else add($sformatf("%0d", $urandom_range(1, 99999)));
                if ($urandom_range(0, 1)) add($sformatf(".%0d", $urandom_range(0, 999)));
                if ($urandom_range(0, 2) == 0)
                begin
                    if ($urandom_range(0, 1)) add("e+");
                    else add("E");
                    add($sformatf("%0d", $urandom_range(0, 99)));
                end
            end
            2, 3:
            begin
                add("\"");
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 7))
                        0: add("\\n");
                        1: add("\\u00e9");
                        2: add("\\ud83d\\ude00");
                        3:
                        begin
                            put_byte(8'hC3); put_byte(8'hA9);
                        end
                        4:
                        begin
                            put_byte(8'hF0); put_byte(8'h9F);
                            put_byte(8'h98); put_byte(8'h80);
                        end
                        default:
                        begin
                            ch = byte'($urandom_range(8'h20, 8'h7E));
                            if (ch == "\"") ch = "a";
                            put_byte(ch);
                        end
                    endcase
                    if (doc[$] == "\\") doc[$] = "x";
                end
                add("\"");
            end
            4:
            begin
                add("[");
                for (int i = $urandom_range(0, 3); i > 0; i--)
                begin
                    gen_value(d + 1);
                    if (i > 1)
                    begin
                        if ($urandom_range(0, 1)) add(",");
                        else add(" , ");
                    end
                end
                add("]");
            end
            default:
            begin
                add("{");
                for (int i = $urandom_range(0, 3); i > 0; i--)
                begin
                    add($sformatf("\"k%0d\"", i));
                    if ($urandom_range(0, 1)) add(":");
                    else add(" :\t");
                    gen_value(d + 1);
                    if (i > 1) add(",");
                end
                add("}");
            end
        endcase
    endtask

    initial
    begin
        string deep;
        in_word = '0;
        in_valid = 1'b0;
        calm = 1'b0;
        bytes_sent = 0;
        docs_sent = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each error code and the edge cases of the grammar
        send_doc(" {\"a\":[1,-0.5e+3,true,false,null,\"\\u00e9\\ud83d\\ude00\"]}\n");
        send_doc(" ");
        send_doc("[");
        deep = "";
        for (int i = 0; i < jssc_pkg::MAX_DEPTH; i++) deep = {deep, "["};
        send_doc({deep, "1"});
        send_doc({deep, "["});
        send_doc({deep, "[1"});
        send_doc("tru");
        send_doc("trux");
        send_doc("{1}");
        send_doc("{\"a\"1}");
        send_doc("{\"a\":1]");
        send_doc("[1}");
        send_doc("-x");
        send_doc("1.x");
        send_doc("1e+x");
        send_doc("\"abc");
        send_doc("\"\\u12");
        send_doc("\"a\tb\"");
        send_doc("\"\\q\"");
        send_doc("\"\\u12G4\"");
        send_doc("\"\\ud800x\"");
        send_doc("\"\\ud800\\u0041\"");
        send_doc("\"\\udc00\"");
        send_doc("1 2");
        put_byte("\""); put_byte(8'hE0); put_byte(8'h80);
        put_byte(8'h80); put_byte("\""); send_queue();
        put_byte("\""); put_byte(8'hC3); add("\\n\""); send_queue();
        put_byte(8'hFF); put_byte(8'h00); send_queue();

        // random: mostly valid documents, some mutated, some raw noise
        while (bytes_sent < 1450)
        begin
            if (bytes_sent > 1250) calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    repeat ($urandom_range(1, 12)) put_byte(byte'($urandom_range(0, 255)));
                    send_queue();
                end
                2, 3:
                begin
                    gen_value(0);
                    if (doc.size() > 1)
                    begin
                        if ($urandom_range(0, 1)) doc[$urandom_range(0, doc.size() - 1)] =
                            byte'($urandom_range(0, 255));
                        else doc = doc[0:$urandom_range(0, doc.size() - 2)];
                    end
                    send_queue();
                end
                default:
                begin
                    gen_value(0);
                    if ($urandom_range(0, 3) == 0) add(" \r\n");
                    send_queue();
                end
            endcase
        end
        in_valid <= 1'b0;

        // drain, then allow the pipeline latency
        while (pending_verdicts != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("%0d documents, %0d bytes sent; %0d verdicts checked", docs_sent,
                 bytes_sent, verdicts_seen);
        $display("covered every error code, depth limit, surrogates and raw UTF-8");
        if (fail_count == 0)
            $display("PASS json_strict_syntax_checker");
        else
            $display("FAIL json_strict_syntax_checker");
        $finish;
    end
endmodule

FILE: files.f
src/jssc_pkg.sv
src/jssc_front.sv
src/jssc_back.sv
src/json_strict_syntax_checker.sv
tb/json_verdict_checker.sv
tb/testbench.sv
